>>> design/iqs_pkg.sv
// Shared constants and types for the iterative quicksort engine.
package iqs_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int VAL_W        = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } iqs_ctrl_t;

  typedef struct packed {
    logic vld;
    logic gt;
    val_t val;
  } iqs_link_t;

endpackage

>>> design/iqs_cell.sv
// One sorting cell: holds an element, inserts in order, shifts out toward cell zero.
module iqs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iqs_pkg::iqs_ctrl_t ctrl_i,
  input  iqs_pkg::val_t     new_val_i,
  input  iqs_pkg::iqs_link_t left_i,
  input  iqs_pkg::iqs_link_t right_i,
  output iqs_pkg::iqs_link_t link_o
);
  import iqs_pkg::*;

  logic vld_q, vld_d;
  val_t val_q, val_d;
  logic gt;

  // new value goes before this element (empty cells count as +inf)
  assign gt = !vld_q || (new_val_i < val_q);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (left_i.gt) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end else if (gt) begin
        vld_d = 1'b1;
        val_d = new_val_i;
      end
    end else if (ctrl_i.shift) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.vld = vld_q;
  assign link_o.gt  = gt;
  assign link_o.val = val_q;

endmodule

>>> design/iterative_quicksort_engine_top.sv
// Top level of the sorting engine: cell chain, batch control and handshakes.
// Usage: elements are taken one per cycle and placed in ascending order on
// arrival by a chain of 64 compare cells, so a batch is already sorted when
// its last element is transferred. Results start the next cycle and leave
// one per cycle from the head of the chain while the output is ready; no
// input is taken until the final result of the batch has been transferred.
// Elements beyond 64 are dropped and every result of that batch shows overflow.
module iterative_quicksort_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iqs_pkg::val_t value_i,
  input  logic          last_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output iqs_pkg::val_t sorted_value_o,
  output logic          last_res_o,
  output logic          overflow_o
);
  import iqs_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             drop_q;
  logic             in_xfer, out_xfer, has_room;
  iqs_ctrl_t        ctrl;
  iqs_link_t        links [MAX_ELEMENTS];

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign has_room    = cnt_q < CNT_W'(MAX_ELEMENTS);

  assign ctrl.ins   = in_xfer && has_room;
  assign ctrl.shift = out_xfer;

  genvar i;
  generate
    for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      iqs_link_t left_w, right_w;
      if (i == 0) begin : g_head
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = links[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_tail
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = links[i+1];
      end
      iqs_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .new_val_i (value_i),
        .left_i    (left_w),
        .right_i   (right_w),
        .link_o    (links[i])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            if (has_room) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (last_i) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            cnt_q <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_LOAD;
              drop_q  <= 1'b0;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign sorted_value_o = links[0].val;
  assign last_res_o     = (cnt_q == CNT_W'(1));
  assign overflow_o     = drop_q;

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> links[0].vld)
    else $error("result shown from an empty head cell");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("emitting with no elements held");

  a_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_res_o) |=> (in_ready_o && cnt_q == '0 && !drop_q))
    else $error("batch state not cleared after final transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count past store size");

endmodule
